// File: rtl/ash_pkg.sv
// Package for the horizontal area-averaging shrink block.
// Payload structs, field widths, register indexes and fixed-point constants.
// No dependencies.
package ash_pkg;

	localparam int PIX_W     = 8;
	localparam int NUM_CH    = 4;
	localparam int SRC_W     = 13;
	localparam int DST_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W    = 17;
	localparam int RECIP_W   = 17;
	localparam int SUM_W     = 16;
	localparam int DIV_NUM_W = 33;
	localparam int ROW_STEP  = 131072;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SRC_WIDTH = 2'd0;
	localparam cfg_idx_t CFG_DST_WIDTH = 2'd1;

	localparam logic [FRAC_W-1:0]    ONE_FIX    = 17'h10000;
	localparam logic [SRC_W-1:0]     SRC_RST    = 13'd2;
	localparam logic [DST_W-1:0]     DST_RST    = 12'd1;
	localparam logic [RECIP_W-1:0]   RECIP_RST  = 17'd32768;
	localparam logic [DIV_NUM_W-1:0] TWO_POW_32 = {1'b1, 32'h0};

	typedef struct packed {
		logic [PIX_W-1:0] pixel_c0;
		logic [PIX_W-1:0] pixel_c1;
		logic [PIX_W-1:0] pixel_c2;
		logic [PIX_W-1:0] pixel_c3;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_c0;
		logic [PIX_W-1:0] out_c1;
		logic [PIX_W-1:0] out_c2;
		logic [PIX_W-1:0] out_c3;
	} res_t;

	// classified item, front to back
	typedef struct packed {
		pix_t              px;
		logic              row_start;
		logic              emit;
		logic [FRAC_W-1:0] frac;
	} item_t;

endpackage

// File: rtl/ash_div.sv
// Restoring divider, one quotient bit per clock.
// Used by the front part to derive the step and its reciprocal. No package use.
module ash_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 29
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/ash_front.sv
// Front part: configuration registers, step/reciprocal derivation, and per-item
// column and fraction tracking that classifies each pixel. Uses ash_pkg, ash_div.
module ash_front import ash_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pix_t             pix,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [SRC_W-1:0] cfg_data,
	input  logic             q_full,
	output logic             push,
	output item_t            item,
	output logic [RECIP_W-1:0] recip
);

	localparam int COL_W  = ($clog2(MAX_WIDTH) > SRC_W) ? SRC_W : $clog2(MAX_WIDTH);
	localparam int STEP_W = COL_W + 17;

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_STEP, ST_RECIP} state_t;

	state_t              state_q;
	logic [SRC_W-1:0]    src_q;
	logic [DST_W-1:0]    dst_q;
	logic [STEP_W-1:0]   step_q;
	logic [RECIP_W-1:0]  recip_q;
	logic [COL_W-1:0]    col_q;
	logic [STEP_W-1:0]   frac_q;

	logic [SRC_W-1:0]     row_len;
	logic [DST_W-1:0]     dst_eff;
	logic                 div_start;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_num;
	logic [STEP_W-1:0]    div_den;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [STEP_W-1:0]    step_new;

	logic                accept;
	logic                cfg_wr;
	logic                cfg_known;
	logic [STEP_W-1:0]   cnt_cur;
	logic                emit;
	logic [FRAC_W-1:0]   rest;
	logic [STEP_W-1:0]   frac_next;
	logic [COL_W:0]      col_inc;
	logic                col_wrap;

	always_comb begin
		row_len = src_q;
		if (src_q == '0)
			row_len = SRC_W'(1);
		else if (int'(src_q) > MAX_WIDTH)
			row_len = SRC_W'(MAX_WIDTH);
		dst_eff = (dst_q == '0) ? DST_W'(1) : dst_q;
	end

	// step saturates at one source pixel per destination pixel
	always_comb begin
		if (div_quo < DIV_NUM_W'(ONE_FIX))
			step_new = STEP_W'(ONE_FIX);
		else
			step_new = div_quo[STEP_W-1:0];
	end

	assign div_start = (state_q == ST_LOAD) || ((state_q == ST_STEP) && div_done);
	assign div_num   = (state_q == ST_LOAD) ? DIV_NUM_W'({row_len, 16'h0}) : TWO_POW_32;
	assign div_den   = (state_q == ST_LOAD) ? STEP_W'(dst_eff) : step_new;

	ash_div #(
		.NUM_W(DIV_NUM_W),
		.DEN_W(STEP_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign cfg_ready = (state_q == ST_IDLE);
	assign pix_stall = (state_q != ST_IDLE) || q_full;
	assign accept    = pix_valid && !pix_stall;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index) inside
			CFG_SRC_WIDTH, CFG_DST_WIDTH: cfg_known = 1'b1;
			default:                      cfg_known = 1'b0;
		endcase
	end

	always_comb begin
		cnt_cur   = (col_q == '0) ? step_q : frac_q;
		emit      = cnt_cur <= STEP_W'(ONE_FIX);
		rest      = ONE_FIX - cnt_cur[FRAC_W-1:0];
		frac_next = emit ? (step_q - STEP_W'(rest)) : (cnt_cur - STEP_W'(ONE_FIX));
		col_inc   = {1'b0, col_q} + 1'b1;
		col_wrap  = (SRC_W+1)'(col_inc) >= {1'b0, row_len};
	end

	assign push = accept;
	assign item = '{px: pix, row_start: (col_q == '0), emit: emit,
		frac: cnt_cur[FRAC_W-1:0]};
	assign recip = recip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			src_q   <= SRC_RST;
			dst_q   <= DST_RST;
			step_q  <= STEP_W'(ROW_STEP);
			recip_q <= RECIP_RST;
			col_q   <= '0;
			frac_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_wr && cfg_known) begin
						if (cfg_index == CFG_SRC_WIDTH)
							src_q <= cfg_data;
						else
							dst_q <= cfg_data[DST_W-1:0];
						col_q   <= '0;
						state_q <= ST_LOAD;
					end else if (accept) begin
						frac_q <= frac_next;
						col_q  <= col_wrap ? '0 : col_inc[COL_W-1:0];
					end
				end
				ST_LOAD: state_q <= ST_STEP;
				ST_STEP: begin
					if (div_done) begin
						step_q  <= step_new;
						state_q <= ST_RECIP;
					end
				end
				ST_RECIP: begin
					if (div_done) begin
						recip_q <= div_quo[RECIP_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/ash_fifo.sv
// Short queue of classified items between the front and back parts.
// Flop storage, first in first out. Uses ash_pkg.
module ash_fifo import ash_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	input  logic  pop,
	output item_t rd_item,
	output logic  empty,
	output logic  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// File: rtl/ash_back.sv
// Back part: partial products, channel sum recurrence, reciprocal scaling
// and the output register. Uses ash_pkg.
module ash_back import ash_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	output logic               pop,
	input  item_t              rd_item,
	input  logic [RECIP_W-1:0] recip,
	output logic               res_valid,
	input  logic               res_stall,
	output res_t               res
);

	logic [NUM_CH-1:0][PIX_W-1:0] px_a;
	logic [FRAC_W-1:0]            rest;
	logic [NUM_CH-1:0][24:0]      part_prod;
	logic [NUM_CH-1:0][24:0]      reload_prod;

	logic                         valid_s1;
	logic                         row_start_s1;
	logic                         emit_s1;
	logic [NUM_CH-1:0][PIX_W-1:0] px_s1;
	logic [NUM_CH-1:0][PIX_W-1:0] part_s1;
	logic [NUM_CH-1:0][PIX_W-1:0] reload_s1;

	logic [NUM_CH-1:0][SUM_W-1:0] sum_q;
	logic [NUM_CH-1:0][SUM_W-1:0] base;
	logic                         valid_s2;
	logic [NUM_CH-1:0][SUM_W:0]   total_s2;

	logic [NUM_CH-1:0][33:0]      scaled;
	logic [NUM_CH-1:0][PIX_W-1:0] out_q;
	logic                         res_valid_q;
	logic                         adv;

	assign adv  = !res_valid_q || !res_stall;
	assign pop  = adv && !empty;
	assign px_a = rd_item.px;
	assign rest = ONE_FIX - rd_item.frac;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			part_prod[c]   = 25'(px_a[c]) * 25'(rd_item.frac);
			reload_prod[c] = 25'(px_a[c]) * 25'(rest);
			base[c]        = row_start_s1 ? '0 : sum_q[c];
			scaled[c]      = 34'(total_s2[c]) * 34'(recip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
			sum_q       <= '0;
		end else if (adv) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1 && emit_s1;
			res_valid_q <= valid_s2;
			if (valid_s1) begin
				for (int c = 0; c < NUM_CH; c++)
					sum_q[c] <= emit_s1 ? SUM_W'(reload_s1[c])
						: base[c] + SUM_W'(px_s1[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_start_s1 <= rd_item.row_start;
			emit_s1      <= rd_item.emit;
			px_s1        <= px_a;
			for (int c = 0; c < NUM_CH; c++) begin
				part_s1[c]   <= part_prod[c][23:16];
				reload_s1[c] <= reload_prod[c][23:16];
				total_s2[c]  <= (SUM_W+1)'(base[c]) + (SUM_W+1)'(part_s1[c]);
				out_q[c]     <= scaled[c][23:16];
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = out_q;

endmodule

// File: rtl/area_shrink_horizontal.sv
// Top level of the horizontal area-averaging shrink block.
// Instantiates ash_front, ash_fifo and ash_back; uses ash_pkg.
//
// Takes one 4-channel pixel per item and emits a destination pixel whenever
// the coverage counter (13.16 at the default MAX_WIDTH) runs out, so a row of
// src_width pixels yields dst_width results (src_width if dst_width is larger);
// the row restarts by itself every src_width items. The front part sustains
// one item per clock as long as the four-entry queue has room and no divider
// run is in progress; the back part is three stages (products, channel sums,
// reciprocal scale into the output register) and drains one item per clock
// while the output is not stalled. A write to a known register reruns a
// one-bit-per-clock divider twice (step, then reciprocal), during which
// pix_stall is high, cfg_ready low. Writes to unknown indexes are taken and dropped.
module area_shrink_horizontal import ash_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pix_t             pix,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [SRC_W-1:0] cfg_data
);

	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	item_t              wr_item;
	item_t              rd_item;
	logic [RECIP_W-1:0] recip;

	ash_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.item     (wr_item),
		.recip    (recip)
	);

	ash_fifo #(
		.DEPTH(4)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_item(wr_item),
		.pop    (pop),
		.rd_item(rd_item),
		.empty  (q_empty),
		.full   (q_full)
	);

	ash_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop      (pop),
		.rd_item  (rd_item),
		.recip    (recip),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// no pixel may enter while the step/reciprocal are being rederived
	a_no_pix_while_deriving: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> pix_stall)
		else $error("pixel accepted during step derivation");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full queue");

	a_recip_range: assert property (@(posedge clk) disable iff (!arst_n)
		(recip != '0) && (recip <= ONE_FIX))
		else $error("reciprocal out of range");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty && !push |=> !(q_empty && pop))
		else $error("pop from empty queue");

endmodule
